### rtl/pts_pkg.sv
// Shared types, codes and helpers for the priority task scheduler.
package pts_pkg;

    localparam int READY_DEPTH_DEF   = 256;
    localparam int DELAYED_DEPTH_DEF = 64;
    localparam int TAG_WIDTH_DEF     = 16;

    localparam int IN_TAG_W = 16;
    localparam int DELAY_W  = 16;
    localparam int TIME_W   = 48;
    localparam int SEQ_W    = 32;

    // Priority codes that carry a rank above best effort
    localparam logic [1:0] PRIO_VISIBLE  = 2'd1;
    localparam logic [1:0] PRIO_BLOCKING = 2'd2;

    // Ranks
    localparam logic [1:0] RANK_LOW  = 2'd1;
    localparam logic [1:0] RANK_MID  = 2'd2;
    localparam logic [1:0] RANK_HIGH = 2'd3;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_TICK = 2'd1,
        OP_DISP = 2'd2,
        OP_SHUT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_REF_SHUT   = 3'd1,
        ST_REF_FULL   = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_NONE_READY = 3'd4,
        ST_STOPPED    = 3'd5,
        ST_DONE       = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]          operation;
        logic [IN_TAG_W-1:0] task_tag;
        logic [1:0]          task_priority;
        logic [DELAY_W-1:0]  delay_ticks;
        logic                blocks_shutdown;
    } t_in_beat;

    typedef struct packed {
        t_status             status;
        logic [IN_TAG_W-1:0] out_tag;
        logic [1:0]          out_priority;
        logic                wake_hint;
    } t_out_beat;

    // Decoded command handed from the front to the engine
    typedef struct packed {
        t_op                 op;
        logic [IN_TAG_W-1:0] tag;
        logic [1:0]          prio;
        logic [DELAY_W-1:0]  delay;
        logic                blocks;
        logic                delayed;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_PICK,
        S_SCAN,
        S_SHIFT,
        S_PRUNE_R,
        S_PRUNE_D
    } t_eng_state;

    typedef enum logic [1:0] {
        P_WAKE,
        P_MOVE,
        P_PICK
    } t_purpose;

    function automatic logic [1:0] rank_of(input logic [1:0] prio);
        logic [1:0] r;
        case (prio)
            PRIO_BLOCKING: r = RANK_HIGH;
            PRIO_VISIBLE:  r = RANK_MID;
            default:       r = RANK_LOW;
        endcase
        return r;
    endfunction

endpackage

### rtl/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pts_front.sv
// Front end: accepts input beats, decodes them and queues commands for the engine.
module pts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pts_pkg::t_in_beat i_in,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output pts_pkg::t_cmd     o_cmd
);

    pts_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    pts_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    // Decode the beat into a command
    always_comb begin
        w_cmd.op      = pts_pkg::t_op'(i_in.operation);
        w_cmd.tag     = i_in.task_tag;
        w_cmd.prio    = i_in.task_priority;
        w_cmd.delay   = i_in.delay_ticks;
        w_cmd.blocks  = i_in.blocks_shutdown;
        w_cmd.delayed = (i_in.delay_ticks != '0);
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

### rtl/pts_engine.sv
// Back end: executes commands against the ready and delayed stores and drives results.
module pts_engine #(
    parameter int READY_DEPTH   = pts_pkg::READY_DEPTH_DEF,
    parameter int DELAYED_DEPTH = pts_pkg::DELAYED_DEPTH_DEF,
    parameter int TAG_WIDTH     = pts_pkg::TAG_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  pts_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pts_pkg::t_out_beat o_out
);

    localparam int TW  = pts_pkg::IN_TAG_W;
    localparam int STW = (TAG_WIDTH < TW) ? TAG_WIDTH : TW;
    localparam int TM  = pts_pkg::TIME_W;
    localparam int TS  = TM + 1;
    localparam int SQ  = pts_pkg::SEQ_W;
    localparam int EW  = STW + SQ + 3;
    localparam int DW  = EW + TM;
    localparam int RAW = $clog2(READY_DEPTH);
    localparam int DAW = $clog2(DELAYED_DEPTH);
    localparam int RCW = $clog2(READY_DEPTH + 1);
    localparam int DCW = $clog2(DELAYED_DEPTH + 1);
    localparam int SW  = (RCW > DCW) ? RCW : DCW;

    pts_pkg::t_eng_state r_state, n_state;
    pts_pkg::t_purpose   r_purp, n_purp;
    pts_pkg::t_cmd       r_cmd, n_cmd;
    pts_pkg::t_out_beat  r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic                r_sel, n_sel;
    logic [RCW-1:0]      r_rcnt, n_rcnt;
    logic [DCW-1:0]      r_dcnt, n_dcnt;
    logic [TM-1:0]       r_time, n_time;
    logic [SQ-1:0]       r_seq, n_seq;
    logic                r_sd, n_sd;
    logic [SW-1:0]       r_src, n_src;
    logic [SW-1:0]       r_ridx, n_ridx;
    logic [SW-1:0]       r_w, n_w;
    logic [SW-1:0]       r_bidx, n_bidx;
    logic                r_rv, n_rv;
    logic                r_have, n_have;
    logic [EW-1:0]       r_best_ent, n_best_ent;
    logic [TM-1:0]       r_best_due, n_best_due;
    logic [TM-1:0]       r_due, n_due;

    logic                w_r_we;
    logic [RAW-1:0]      w_r_waddr;
    logic [EW-1:0]       w_r_wdata;
    logic [EW-1:0]       w_r_rdata;
    logic                w_d_we;
    logic [DAW-1:0]      w_d_waddr;
    logic [DW-1:0]       w_d_wdata;
    logic [DW-1:0]       w_d_rdata;

    logic [SW-1:0]       w_cnt_sel;
    logic                w_issue;
    logic                w_pass_done;
    logic [EW-1:0]       w_c_ent;
    logic [TM-1:0]       w_c_due;
    logic [1:0]          w_c_rank;
    logic [1:0]          w_b_rank;
    logic                w_better;
    logic                w_c_blocks;
    logic [EW-1:0]       w_new_ent;
    logic [TS-1:0]       w_due_sum;
    logic [TM-1:0]       w_due;
    logic [SW-1:0]       w_wr_back;

    pts_ram #(.WIDTH(EW), .DEPTH(READY_DEPTH)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (w_r_we),
        .i_waddr (w_r_waddr),
        .i_wdata (w_r_wdata),
        .i_raddr (r_src[RAW-1:0]),
        .o_rdata (w_r_rdata)
    );

    pts_ram #(.WIDTH(DW), .DEPTH(DELAYED_DEPTH)) u_delayed_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (r_src[DAW-1:0]),
        .o_rdata (w_d_rdata)
    );

    // Walk state shared by scan, shift and compaction passes
    assign w_cnt_sel   = r_sel ? SW'(r_dcnt) : SW'(r_rcnt);
    assign w_issue     = (r_src < w_cnt_sel);
    assign w_pass_done = !w_issue && !r_rv;
    assign w_wr_back   = r_ridx - SW'(1);

    // Candidate entry from the store being walked
    assign w_c_ent    = r_sel ? w_d_rdata[DW-1:TM] : w_r_rdata;
    assign w_c_due    = r_sel ? w_d_rdata[TM-1:0] : '0;
    assign w_c_blocks = w_c_ent[SQ];
    assign w_c_rank   = pts_pkg::rank_of(w_c_ent[SQ+2:SQ+1]);
    assign w_b_rank   = pts_pkg::rank_of(r_best_ent[SQ+2:SQ+1]);
    assign w_better   = (w_c_due < r_best_due) ||
                        ((w_c_due == r_best_due) &&
                         ((w_c_rank > w_b_rank) ||
                          ((w_c_rank == w_b_rank) &&
                           (w_c_ent[SQ-1:0] < r_best_ent[SQ-1:0]))));

    // New entry and its saturated due time
    assign w_new_ent = {r_cmd.tag[STW-1:0], r_cmd.prio, r_cmd.blocks, r_seq};
    assign w_due_sum = {1'b0, r_time} + TS'(r_cmd.delay);
    assign w_due     = w_due_sum[TM] ? '1 : w_due_sum[TM-1:0];

    // Sequence the command
    always_comb begin
        n_state     = r_state;
        n_purp      = r_purp;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_sel       = r_sel;
        n_rcnt      = r_rcnt;
        n_dcnt      = r_dcnt;
        n_time      = r_time;
        n_seq       = r_seq;
        n_sd        = r_sd;
        n_src       = r_src;
        n_ridx      = r_ridx;
        n_w         = r_w;
        n_bidx      = r_bidx;
        n_rv        = 1'b0;
        n_have      = r_have;
        n_best_ent  = r_best_ent;
        n_best_due  = r_best_due;
        n_due       = r_due;
        o_cmd_pop   = 1'b0;
        w_r_we      = 1'b0;
        w_r_waddr   = r_rcnt[RAW-1:0];
        w_r_wdata   = w_new_ent;
        w_d_we      = 1'b0;
        w_d_waddr   = r_dcnt[DAW-1:0];
        w_d_wdata   = {w_new_ent, w_due};

        case (r_state)
            pts_pkg::S_IDLE: begin
                o_cmd_pop = i_cmd_valid && !r_out_valid;
                if (o_cmd_pop) begin
                    n_cmd   = i_cmd;
                    n_state = pts_pkg::S_EXEC;
                end
            end

            pts_pkg::S_EXEC: begin
                n_out.status       = pts_pkg::ST_DONE;
                n_out.out_tag      = '0;
                n_out.out_priority = '0;
                n_out.wake_hint    = 1'b0;
                n_state            = pts_pkg::S_IDLE;
                n_out_valid        = 1'b1;
                n_src              = '0;
                n_have             = 1'b0;
                n_w                = '0;
                case (r_cmd.op)
                    pts_pkg::OP_ENQ: begin
                        if (r_sd) begin
                            n_out.status = pts_pkg::ST_REF_SHUT;
                        end else if (!r_cmd.delayed) begin
                            if (r_rcnt == RCW'(READY_DEPTH)) begin
                                n_out.status = pts_pkg::ST_REF_FULL;
                            end else begin
                                w_r_we          = 1'b1;
                                n_out.wake_hint = (r_rcnt == '0);
                                n_rcnt          = r_rcnt + RCW'(1);
                                n_seq           = r_seq + SQ'(1);
                                n_out.status    = pts_pkg::ST_ACCEPTED;
                            end
                        end else if (r_dcnt == DCW'(DELAYED_DEPTH)) begin
                            n_out.status = pts_pkg::ST_REF_FULL;
                        end else if (r_dcnt == '0) begin
                            w_d_we          = 1'b1;
                            n_out.wake_hint = (r_rcnt == '0);
                            n_dcnt          = r_dcnt + DCW'(1);
                            n_seq           = r_seq + SQ'(1);
                            n_out.status    = pts_pkg::ST_ACCEPTED;
                        end else begin
                            // Find the earliest due time before deciding on a wake
                            n_due       = w_due;
                            n_sel       = 1'b1;
                            n_purp      = pts_pkg::P_WAKE;
                            n_state     = pts_pkg::S_SCAN;
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    end
                    pts_pkg::OP_TICK: begin
                        if (r_time != '1) begin
                            n_time = r_time + TM'(1);
                        end
                    end
                    pts_pkg::OP_DISP: begin
                        if (r_sd && r_rcnt == '0 && r_dcnt == '0) begin
                            n_out.status = pts_pkg::ST_STOPPED;
                        end else begin
                            n_state     = pts_pkg::S_MOVE;
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    end
                    pts_pkg::OP_SHUT: begin
                        if (!r_sd) begin
                            n_sd        = 1'b1;
                            n_sel       = 1'b0;
                            n_state     = pts_pkg::S_PRUNE_R;
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    end
                    default: begin
                        n_state = pts_pkg::S_IDLE;
                    end
                endcase
            end

            pts_pkg::S_MOVE: begin
                n_src  = '0;
                n_have = 1'b0;
                if (r_dcnt != '0 && r_rcnt < RCW'(READY_DEPTH)) begin
                    n_sel   = 1'b1;
                    n_purp  = pts_pkg::P_MOVE;
                    n_state = pts_pkg::S_SCAN;
                end else begin
                    n_state = pts_pkg::S_PICK;
                end
            end

            pts_pkg::S_PICK: begin
                n_src  = '0;
                n_have = 1'b0;
                if (r_rcnt != '0) begin
                    n_sel   = 1'b0;
                    n_purp  = pts_pkg::P_PICK;
                    n_state = pts_pkg::S_SCAN;
                end else begin
                    n_out.status       = pts_pkg::ST_NONE_READY;
                    n_out.out_tag      = '0;
                    n_out.out_priority = '0;
                    n_out.wake_hint    = 1'b0;
                    n_out_valid        = 1'b1;
                    n_state            = pts_pkg::S_IDLE;
                end
            end

            pts_pkg::S_SCAN: begin
                // Issue reads in order and keep the best entry seen
                if (w_issue) begin
                    n_src  = r_src + SW'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_src;
                end
                if (r_rv && (!r_have || w_better)) begin
                    n_have     = 1'b1;
                    n_best_ent = w_c_ent;
                    n_best_due = w_c_due;
                    n_bidx     = r_ridx;
                end
                if (w_pass_done) begin
                    n_src = r_bidx + SW'(1);
                    case (r_purp)
                        pts_pkg::P_WAKE: begin
                            w_d_we             = 1'b1;
                            w_d_wdata          = {w_new_ent, r_due};
                            n_dcnt             = r_dcnt + DCW'(1);
                            n_seq              = r_seq + SQ'(1);
                            n_out.status       = pts_pkg::ST_ACCEPTED;
                            n_out.out_tag      = '0;
                            n_out.out_priority = '0;
                            n_out.wake_hint    = (r_due < r_best_due);
                            n_out_valid        = 1'b1;
                            n_state            = pts_pkg::S_IDLE;
                        end
                        pts_pkg::P_MOVE: begin
                            if (r_best_due > r_time) begin
                                n_state = pts_pkg::S_PICK;
                            end else begin
                                w_r_we    = 1'b1;
                                w_r_wdata = r_best_ent;
                                n_rcnt    = r_rcnt + RCW'(1);
                                n_state   = pts_pkg::S_SHIFT;
                            end
                        end
                        default: begin
                            n_state = pts_pkg::S_SHIFT;
                        end
                    endcase
                end
            end

            pts_pkg::S_SHIFT: begin
                // Close the gap left by the removed entry
                if (w_issue) begin
                    n_src  = r_src + SW'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_src;
                end
                if (r_rv) begin
                    if (r_sel) begin
                        w_d_we    = 1'b1;
                        w_d_waddr = w_wr_back[DAW-1:0];
                        w_d_wdata = w_d_rdata;
                    end else begin
                        w_r_we    = 1'b1;
                        w_r_waddr = w_wr_back[RAW-1:0];
                        w_r_wdata = w_r_rdata;
                    end
                end
                if (w_pass_done) begin
                    if (r_sel) begin
                        n_dcnt  = r_dcnt - DCW'(1);
                        n_state = pts_pkg::S_MOVE;
                    end else begin
                        n_rcnt             = r_rcnt - RCW'(1);
                        n_out.status       = pts_pkg::ST_DISPATCHED;
                        n_out.out_tag      = TW'(r_best_ent[EW-1:SQ+3]);
                        n_out.out_priority = r_best_ent[SQ+2:SQ+1];
                        n_out.wake_hint    = 1'b0;
                        n_out_valid        = 1'b1;
                        n_state            = pts_pkg::S_IDLE;
                    end
                end
            end

            pts_pkg::S_PRUNE_R, pts_pkg::S_PRUNE_D: begin
                // Compact the store, keeping only blocking tasks
                if (w_issue) begin
                    n_src  = r_src + SW'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_src;
                end
                if (r_rv && w_c_blocks) begin
                    n_w = r_w + SW'(1);
                    if (r_sel) begin
                        w_d_we    = 1'b1;
                        w_d_waddr = r_w[DAW-1:0];
                        w_d_wdata = w_d_rdata;
                    end else begin
                        w_r_we    = 1'b1;
                        w_r_waddr = r_w[RAW-1:0];
                        w_r_wdata = w_r_rdata;
                    end
                end
                if (w_pass_done) begin
                    n_src = '0;
                    n_w   = '0;
                    if (r_state == pts_pkg::S_PRUNE_R) begin
                        n_rcnt  = r_w[RCW-1:0];
                        n_sel   = 1'b1;
                        n_state = pts_pkg::S_PRUNE_D;
                    end else begin
                        n_dcnt             = r_w[DCW-1:0];
                        n_out.status       = pts_pkg::ST_DONE;
                        n_out.out_tag      = '0;
                        n_out.out_priority = '0;
                        n_out.wake_hint    = 1'b0;
                        n_out_valid        = 1'b1;
                        n_state            = pts_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pts_pkg::S_IDLE;
            r_purp      <= pts_pkg::P_WAKE;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
            r_rcnt      <= '0;
            r_dcnt      <= '0;
            r_time      <= '0;
            r_seq       <= '0;
            r_sd        <= 1'b0;
            r_src       <= '0;
            r_ridx      <= '0;
            r_w         <= '0;
            r_rv        <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_purp      <= n_purp;
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
            r_rcnt      <= n_rcnt;
            r_dcnt      <= n_dcnt;
            r_time      <= n_time;
            r_seq       <= n_seq;
            r_sd        <= n_sd;
            r_src       <= n_src;
            r_ridx      <= n_ridx;
            r_w         <= n_w;
            r_rv        <= n_rv;
            r_have      <= n_have;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out      <= n_out;
        r_bidx     <= n_bidx;
        r_best_ent <= n_best_ent;
        r_best_due <= n_best_due;
        r_due      <= n_due;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RCW'(READY_DEPTH))
        else $error("ready count exceeds depth");

    a_delayed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DCW'(DELAYED_DEPTH))
        else $error("delayed count exceeds depth");

    a_shutdown_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd |=> r_sd)
        else $error("shutdown flag cleared without reset");

    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("current time went backward");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == pts_pkg::S_IDLE) && !r_out_valid)
        else $error("command taken while busy");

endmodule

### rtl/priority_task_scheduler_with_delays.sv
// Tick, refused enqueue, zero-delay enqueue and a delayed enqueue into an empty delayed
// store finish in the execute state; a delayed enqueue behind a nonempty delayed store
// scans it. Dispatch scans the delayed store once per due task moved and once more while
// entries remain and the ready store has room, the ready store once, plus a shift of the
// store tail after each removal; shutdown compacts both stores. Throughput: one item at a
// time in the engine; a two-beat command queue decouples input. Reset (synchronous, active
// low) empties both stores, zeroes time and sequence, clears shutdown.
module priority_task_scheduler_with_delays #(
    parameter int READY_DEPTH   = pts_pkg::READY_DEPTH_DEF,
    parameter int DELAYED_DEPTH = pts_pkg::DELAYED_DEPTH_DEF,
    parameter int TAG_WIDTH     = pts_pkg::TAG_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pts_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pts_pkg::t_out_beat o_out
);

    logic          w_cmd_valid;
    logic          w_cmd_pop;
    pts_pkg::t_cmd w_cmd;

    // Accept and decode beats
    pts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // Execute commands against the stores
    pts_engine #(
        .READY_DEPTH   (READY_DEPTH),
        .DELAYED_DEPTH (DELAYED_DEPTH),
        .TAG_WIDTH     (TAG_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
